[rtl/ray_box_slab_test_defines.svh]
// assertion macros shared by the ray box slab test rtl
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RBST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rbst_pkg.sv]
// types, constants and slab arithmetic helpers for the ray box slab test
package rbst_pkg;

  localparam int DivBits       = 32;
  localparam int StepsPerStage = 4;
  localparam int DivStages     = DivBits / StepsPerStage;
  localparam int NumLanes      = 6;
  localparam int NumAxes       = 3;

  localparam logic [31:0] QMax = 32'h7fff_ffff;
  localparam logic [31:0] QMin = 32'h8000_0000;

  // one plane division in flight
  typedef struct packed {
    logic [31:0] rem;   // partial remainder
    logic [31:0] dq;    // dividend bits left, quotient bits shifted in
    logic [31:0] dvs;   // divisor magnitude
    logic        neg;   // quotient sign
    logic        fix;   // result already known (zero direction or overflow)
    logic [31:0] fval;  // that known result
  } lane_t;

  typedef lane_t [NumLanes-1:0] lanes_t;

  // set up one plane: |bound - start| * 2^16 / |dir|
  function automatic lane_t lane_init(logic [31:0] bound, logic [31:0] start,
                                      logic [31:0] dir, logic upper);
    logic signed [32:0] num;
    logic [32:0]        mag;
    logic [31:0]        dmag;
    logic               nneg;
    lane_t              l;
    num  = $signed({bound[31], bound}) - $signed({start[31], start});
    nneg = num[32];
    mag  = nneg ? 33'(-num) : 33'(num);
    dmag = dir[31] ? 32'(-dir) : dir;
    l.neg = nneg ^ dir[31];
    l.dvs = dmag;
    l.rem = {15'b0, mag[32:16]};
    l.dq  = {mag[15:0], 16'b0};
    if (dir == '0) begin
      l.fix  = 1'b1;
      if (num == '0) l.fval = upper ? QMax : QMin;
      else           l.fval = nneg ? QMin : QMax;
    end else if ({14'b0, mag[32:15]} >= dmag) begin
      // quotient would reach 2^31 or more
      l.fix  = 1'b1;
      l.fval = l.neg ? QMin : QMax;
    end else begin
      l.fix  = 1'b0;
      l.fval = '0;
    end
    return l;
  endfunction

  // one restoring division step
  function automatic lane_t div_step(lane_t l);
    logic [32:0] r;
    logic [32:0] d;
    lane_t       o;
    o = l;
    r = {l.rem, l.dq[31]};
    d = {1'b0, l.dvs};
    if (r >= d) begin
      o.rem = 32'(r - d);
      o.dq  = {l.dq[30:0], 1'b1};
    end else begin
      o.rem = r[31:0];
      o.dq  = {l.dq[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] lane_value(lane_t l);
    logic [31:0] v;
    if (l.fix)      v = l.fval;
    else if (l.neg) v = 32'(-l.dq);
    else            v = l.dq;
    return v;
  endfunction

endpackage

[rtl/rbst_prep.sv]
// input stage: plane numerators, divisor magnitudes and special cases
`include "ray_box_slab_test_defines.svh"
module rbst_prep import rbst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] start_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [31:0] box_min_x,
  input  logic [31:0] box_min_y,
  input  logic [31:0] box_min_z,
  input  logic [31:0] box_max_x,
  input  logic [31:0] box_max_y,
  input  logic [31:0] box_max_z,
  output logic        valid,
  output lanes_t      lanes
);

  lanes_t lanes_next;

  always_comb begin
    lanes_next[0] = lane_init(box_min_x, start_x, dir_x, 1'b0);
    lanes_next[1] = lane_init(box_max_x, start_x, dir_x, 1'b1);
    lanes_next[2] = lane_init(box_min_y, start_y, dir_y, 1'b0);
    lanes_next[3] = lane_init(box_max_y, start_y, dir_y, 1'b1);
    lanes_next[4] = lane_init(box_min_z, start_z, dir_z, 1'b0);
    lanes_next[5] = lane_init(box_max_z, start_z, dir_z, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes <= lanes_next;
    end
  end

  `RBST_ASSERT_IMP(a_zero_dir_fixed, valid && lanes[0].dvs == '0, lanes[0].fix && lanes[1].fix, "zero x direction not resolved early")

endmodule

[rtl/rbst_div_stage.sv]
// one divider stage: a few restoring steps on all six planes
`include "ray_box_slab_test_defines.svh"
module rbst_div_stage import rbst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  lanes_t in_lanes,
  output logic   valid,
  output lanes_t lanes
);

  lanes_t lanes_next;

  always_comb begin
    lanes_next = in_lanes;
    for (int i = 0; i < NumLanes; i++) begin
      for (int s = 0; s < StepsPerStage; s++) begin
        lanes_next[i] = div_step(lanes_next[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes <= lanes_next;
    end
  end

  `RBST_ASSERT_NXT(a_blocked_holds, valid && !en, valid, "blocked divider stage dropped its item")

endmodule

[rtl/rbst_reduce.sv]
// tail: signed slab values, per-axis ordering, interval overlap
`include "ray_box_slab_test_defines.svh"
module rbst_reduce import rbst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  lanes_t in_lanes,
  output logic   ready,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   hit
);

  logic                     va, vb;
  logic                     en_a, en_b, en_c;
  logic signed [31:0]       lo [NumAxes];
  logic signed [31:0]       hi [NumAxes];
  logic signed [31:0]       lo_next [NumAxes];
  logic signed [31:0]       hi_next [NumAxes];
  logic signed [31:0]       xy_lo, xy_hi, z_lo, z_hi;
  logic                     xy_ok;
  logic                     hit_next;

  assign en_c  = !out_valid || !out_stall;
  assign en_b  = !vb || en_c;
  assign en_a  = !va || en_b;
  assign ready = en_a;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      logic signed [31:0] p, q;
      p = $signed(lane_value(in_lanes[2*a]));
      q = $signed(lane_value(in_lanes[2*a+1]));
      lo_next[a] = (p > q) ? q : p;
      hi_next[a] = (p > q) ? p : q;
    end
  end

  assign hit_next = xy_ok && !(xy_lo > z_hi || z_lo > xy_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va        <= in_valid;
      if (en_b) vb        <= va;
      if (en_c) out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (en_b) begin
      xy_ok <= !(lo[0] > hi[1] || lo[1] > hi[0]);
      xy_lo <= (lo[1] > lo[0]) ? lo[1] : lo[0];
      xy_hi <= (hi[1] < hi[0]) ? hi[1] : hi[0];
      z_lo  <= lo[2];
      z_hi  <= hi[2];
    end
    if (en_c) begin
      hit <= hit_next;
    end
  end

  `RBST_ASSERT_IMP(a_axes_ordered, va, lo[0] <= hi[0] && lo[1] <= hi[1] && lo[2] <= hi[2], "slab interval out of order")

endmodule

[rtl/ray_box_slab_test.sv]
// top level of the ray versus axis-aligned box slab test pipeline
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------
//   in      | in_valid  | in_stall  | start_*, dir_*, box_min_*, box_max_*
//   out     | out_valid | out_stall | hit
//
// one test per cycle sustained while out is not stalled; 1 setup stage, 8 divider
// stages of 4 restoring steps each, 3 compare stages
// the six plane divisions share the divider pipeline in parallel lanes
// each stage advances when it is empty or the next stage advances, so bubbles
// close up and in_stall rises only when every stage is full and out is stalled
// rst clears the valid bits only
`include "ray_box_slab_test_defines.svh"
module ray_box_slab_test import rbst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] start_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [31:0] box_min_x,
  input  logic [31:0] box_min_y,
  input  logic [31:0] box_min_z,
  input  logic [31:0] box_max_x,
  input  logic [31:0] box_max_y,
  input  logic [31:0] box_max_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit
);

  logic                 p_valid;
  lanes_t               p_lanes;
  logic                 p_en;
  logic [DivStages-1:0] d_valid;
  logic [DivStages-1:0] d_en;
  lanes_t               d_lanes [DivStages];
  logic                 red_ready;

  assign p_en     = !p_valid || d_en[0];
  assign in_stall = !p_en;

  rbst_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (p_en),
    .in_valid  (in_valid),
    .start_x   (start_x),
    .start_y   (start_y),
    .start_z   (start_z),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .valid     (p_valid),
    .lanes     (p_lanes)
  );

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    if (k == DivStages - 1) begin : g_last
      assign d_en[k] = !d_valid[k] || red_ready;
    end else begin : g_mid
      assign d_en[k] = !d_valid[k] || d_en[k+1];
    end

    if (k == 0) begin : g_first
      rbst_div_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .en       (d_en[k]),
        .in_valid (p_valid),
        .in_lanes (p_lanes),
        .valid    (d_valid[k]),
        .lanes    (d_lanes[k])
      );
    end else begin : g_rest
      rbst_div_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .en       (d_en[k]),
        .in_valid (d_valid[k-1]),
        .in_lanes (d_lanes[k-1]),
        .valid    (d_valid[k]),
        .lanes    (d_lanes[k])
      );
    end
  end

  rbst_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid[DivStages-1]),
    .in_lanes  (d_lanes[DivStages-1]),
    .ready     (red_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
  );

  `RBST_ASSERT_IMP(a_stall_only_when_backed_up, in_stall, out_valid && out_stall && p_valid, "input stalled while pipeline can advance")

endmodule
